// File: hw/rtl/fcfs_pkg.sv
// ----------------------------------------------------------------------------
// fcfs_pkg
// Shared constants and types for the arrival-order dispatch block.
// ----------------------------------------------------------------------------
package fcfs_pkg;

  // fixed widths of the port fields
  localparam int PORT_TIME_W = 16;
  localparam int PORT_ID_W   = 5;

  // per-cycle strobes for the entry store
  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

endpackage

// File: hw/rtl/fcfs_store.sv
// ----------------------------------------------------------------------------
// fcfs_store
// Entry memory for the sorted process list: one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module fcfs_store import fcfs_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 37,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  store_ctl_t        ctl,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/fcfs_arrival_order_dispatch.sv
// ----------------------------------------------------------------------------
// fcfs_arrival_order_dispatch
// Collects a batch of processes into a list sorted by arrival time and
// dispatches them in first-come-first-served order on the batch end.
// ----------------------------------------------------------------------------
// Load: a request writes its entry after moving up each held entry with a
// later arrival, one slot at a time, through the single memory port pair and
// the one arrival compare. A request that finds the store full is dropped.
// Dispatch of N entries: one read per cycle, results registered in list order
// once the load ends; busy stays high until the last read is issued. Results cannot
// be stalled. Synchronous reset empties the list and clears the overflow flag.
module fcfs_arrival_order_dispatch import fcfs_pkg::*; #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [PORT_TIME_W-1:0] arrival_time,
  input  logic [PORT_TIME_W-1:0] burst_time,
  input  logic                   batch_end,
  output logic                   dispatch_valid,
  output logic [PORT_ID_W-1:0]   process_id,
  output logic [PORT_TIME_W-1:0] arrival_out,
  output logic [PORT_TIME_W-1:0] burst_out,
  output logic                   last_dispatch,
  output logic                   overflowed
);

  localparam int IDX_W  = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int DATA_W = CNT_W + 2 * TIME_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DISP = 2'd2;

  logic [1:0]           state, state_next;
  logic [CNT_W-1:0]     held, held_next;
  logic                 ovf, ovf_next;
  logic [IDX_W-1:0]     pos, pos_next;
  logic [IDX_W-1:0]     k, k_next;
  logic [TIME_BITS-1:0] arr_q, arr_next;
  logic [TIME_BITS-1:0] bur_q, bur_next;
  logic                 last_q, last_next;
  logic                 out_valid, out_valid_next;
  logic                 out_last, out_last_next;
  logic                 out_ovf, out_ovf_next;

  store_ctl_t           ctl;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [DATA_W-1:0]    wdata, rdata;
  logic [CNT_W-1:0]     rd_id;
  logic [TIME_BITS-1:0] rd_arr, rd_bur;
  logic [31:0]          arr_in_w, bur_in_w;
  logic [31:0]          id_w, arr_w, bur_w;
  logic                 full;

  assign arr_in_w = 32'(arrival_time);
  assign bur_in_w = 32'(burst_time);
  assign {rd_id, rd_arr, rd_bur} = rdata;
  assign full = (held == CNT_W'(MAX_PROCS));

  fcfs_store #(
    .DEPTH  (MAX_PROCS),
    .DATA_W (DATA_W)
  ) u_store (
    .clk   (clk),
    .ctl   (ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    held_next      = held;
    ovf_next       = ovf;
    pos_next       = pos;
    k_next         = k;
    arr_next       = arr_q;
    bur_next       = bur_q;
    last_next      = last_q;
    out_valid_next = 1'b0;
    out_last_next  = 1'b0;
    out_ovf_next   = out_ovf;
    ctl            = '0;
    waddr          = pos;
    wdata          = {held + 1'b1, arr_q, bur_q};
    raddr          = k;
    case (state)
      S_IDLE: begin
        if (start) begin
          arr_next  = arr_in_w[TIME_BITS-1:0];
          bur_next  = bur_in_w[TIME_BITS-1:0];
          last_next = batch_end;
          if (full) begin
            ovf_next = 1'b1;
            if (batch_end) begin
              k_next     = '0;
              state_next = S_DISP;
            end
          end else begin
            pos_next   = held[IDX_W-1:0];
            raddr      = held[IDX_W-1:0] - 1'b1;
            ctl.re     = (held != '0);
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        // move the later-arriving neighbor up while prefetching the next one
        if (pos != '0 && rd_arr > arr_q) begin
          ctl.we   = 1'b1;
          wdata    = rdata;
          pos_next = pos - 1'b1;
          ctl.re   = 1'b1;
          raddr    = pos - IDX_W'(2);
        end else begin
          ctl.we    = 1'b1;
          held_next = held + 1'b1;
          if (last_q) begin
            k_next     = '0;
            state_next = S_DISP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DISP: begin
        ctl.re         = 1'b1;
        out_valid_next = 1'b1;
        out_ovf_next   = ovf;
        if (CNT_W'(k) + 1'b1 == held) begin
          out_last_next = 1'b1;
          held_next     = '0;
          ovf_next      = 1'b0;
          state_next    = S_IDLE;
        end else begin
          k_next = k + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      out_ovf   <= 1'b0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
      out_last  <= out_last_next;
      out_ovf   <= out_ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    k      <= k_next;
    arr_q  <= arr_next;
    bur_q  <= bur_next;
    last_q <= last_next;
  end

  assign id_w  = 32'(rd_id);
  assign arr_w = 32'(rd_arr);
  assign bur_w = 32'(rd_bur);

  assign busy           = (state != S_IDLE);
  assign dispatch_valid = out_valid;
  assign process_id     = id_w[PORT_ID_W-1:0];
  assign arrival_out    = arr_w[PORT_TIME_W-1:0];
  assign burst_out      = bur_w[PORT_TIME_W-1:0];
  assign last_dispatch  = out_last;
  assign overflowed     = out_ovf;

  // list never grows past capacity
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(MAX_PROCS))
    else $error("held count above capacity");

  // a request that fits always goes through the insertion scan
  a_load_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !full) |=> (state == S_CMP))
    else $error("accepted request skipped insertion");

  // final result closes the run: list emptied, no further strobe
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (dispatch_valid && last_dispatch) |-> (held == '0 && !ovf && state == S_IDLE))
    else $error("dispatch run did not close");

  // insertion only happens with a free slot
  a_cmp_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> !full)
    else $error("insertion into a full list");

endmodule
